// ===== hw/rtl/s2x_pkg.sv =====
// Shared constants, codes and inter-module structs of the Scale2x upscaler.
`timescale 1ns / 1ps
package s2x_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 32;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CFG_BITS   = 11;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(320);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // controls of one line store for one cycle
  typedef struct packed {
    logic                  we;
    logic [COL_BITS-1:0]   waddr;
    logic [PIXEL_BITS-1:0] wdata;
    logic                  re;
    logic [COL_BITS-1:0]   raddr0;
    logic [COL_BITS-1:0]   raddr1;
  } s2x_ram_ctl_t;

  // item handed from the controller to the kernel stage
  typedef struct packed {
    logic                  valid;
    logic [COL_BITS-1:0]   col;
    logic                  last;
    logic                  drain;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  top_row;
    logic                  sel;
    logic [PIXEL_BITS-1:0] d_hold;
  } s2x_issue_t;

  // status of the kernel's read stage, seen by the controller
  typedef struct packed {
    logic                  busy;
    logic                  adv;
    logic [COL_BITS-1:0]   col;
    logic [PIXEL_BITS-1:0] e;
  } s2x_stage_t;

endpackage

// ===== hw/rtl/scale2x_pixel_upscaler_core.sv =====
// Top level of the streaming Scale2x pixel upscaler.
//
// Input channel (in_valid/in_ready): one word per source pixel in raster
// order (in_op = pixel) or, after the last row, one drain word per column
// (in_op = drain). The first row of a frame is only stored; each later
// pixel yields the 2x2 block of the pixel above it, and the drain words
// yield the bottom row. Drain words before the second row are dropped.
// Output channel (out_valid/out_ready): four output pixels plus column,
// row end and frame end flags. Configuration (cfg_valid/cfg_data, always
// ready) sets the row width; write it only while the block is idle.
// An accepted word passes the read stage, then the output register, before out_valid rises.
// Throughput is one word per cycle while the receiver takes results, set by the
// two-read-port line stores; after a width change in mid-row the first word is held
// off while its left neighbor is refetched from the centre store.
// A stalled receiver holds the output register; one more word is then
// taken into the read stage before in_ready drops.
// Reset (rst_n, synchronous) returns to the start of a frame with width
// 320; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module scale2x_pixel_upscaler_core import s2x_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_top_left,
  output logic [PIXEL_BITS-1:0] out_top_right,
  output logic [PIXEL_BITS-1:0] out_bottom_left,
  output logic [PIXEL_BITS-1:0] out_bottom_right,
  output logic [COL_BITS-1:0]   out_centre_column,
  output logic                  out_row_end,
  output logic                  out_frame_end
);

  s2x_ram_ctl_t [1:0]    ram_ctl;
  s2x_issue_t            issue;
  s2x_stage_t            stage;
  logic [PIXEL_BITS-1:0] ram0_rd0, ram0_rd1;
  logic [PIXEL_BITS-1:0] ram1_rd0, ram1_rd1;

  s2x_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_pixel  (in_pixel),
    .ram0_rd0  (ram0_rd0),
    .ram1_rd0  (ram1_rd0),
    .stage     (stage),
    .issue     (issue),
    .ram_ctl   (ram_ctl)
  );

  // centre_row_store
  s2x_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram0 (
    .clk    (clk),
    .we     (ram_ctl[0].we),
    .waddr  (ram_ctl[0].waddr),
    .wdata  (ram_ctl[0].wdata),
    .re     (ram_ctl[0].re),
    .raddr0 (ram_ctl[0].raddr0),
    .raddr1 (ram_ctl[0].raddr1),
    .rdata0 (ram0_rd0),
    .rdata1 (ram0_rd1)
  );

  // upper_row_store
  s2x_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram1 (
    .clk    (clk),
    .we     (ram_ctl[1].we),
    .waddr  (ram_ctl[1].waddr),
    .wdata  (ram_ctl[1].wdata),
    .re     (ram_ctl[1].re),
    .raddr0 (ram_ctl[1].raddr0),
    .raddr1 (ram_ctl[1].raddr1),
    .rdata0 (ram1_rd0),
    .rdata1 (ram1_rd1)
  );

  s2x_kernel u_kernel (
    .clk               (clk),
    .rst_n             (rst_n),
    .issue             (issue),
    .stage             (stage),
    .ram0_rd0          (ram0_rd0),
    .ram0_rd1          (ram0_rd1),
    .ram1_rd0          (ram1_rd0),
    .ram1_rd1          (ram1_rd1),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_top_left      (out_top_left),
    .out_top_right     (out_top_right),
    .out_bottom_left   (out_bottom_left),
    .out_bottom_right  (out_bottom_right),
    .out_centre_column (out_centre_column),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end)
  );

endmodule

// ===== hw/rtl/s2x_ram.sv =====
// Generic simple dual-port RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module s2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr0,
  input  logic [ADDR_BITS-1:0] raddr1,
  output logic [WIDTH-1:0]     rdata0,
  output logic [WIDTH-1:0]     rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== hw/rtl/s2x_ctrl.sv =====
// Frame/row sequencing, width register, line store addressing and left-neighbor tracking.
`timescale 1ns / 1ps
module s2x_ctrl import s2x_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic [PIXEL_BITS-1:0] ram0_rd0,
  input  logic [PIXEL_BITS-1:0] ram1_rd0,
  input  s2x_stage_t            stage,
  output s2x_issue_t            issue,
  output s2x_ram_ctl_t [1:0]    ram_ctl
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_CAP = 2'b10
  } s2x_state_t;

  s2x_state_t            st_r, st_nxt;
  logic [CFG_BITS-1:0]   width_r, width_nxt;
  logic [COL_BITS-1:0]   count_r, count_nxt;
  logic                  sel_r, sel_nxt;
  logic                  filling_r, filling_nxt;
  logic                  top_r, top_nxt;
  logic [PIXEL_BITS-1:0] d_hold_r, d_hold_nxt;
  logic [COL_BITS-1:0]   d_col_r, d_col_nxt;
  logic                  d_ok_r, d_ok_nxt;
  logic [COL_BITS-1:0]   pre_col_r, pre_col_nxt;

  logic [CFG_BITS-1:0] wdec;
  logic [COL_BITS-1:0] wm1;
  logic [COL_BITS-1:0] col;
  logic [COL_BITS-1:0] col_m1;
  logic [COL_BITS-1:0] col_p1;
  logic                last;
  logic                is_drain;
  logic                eff_ok;
  logic [COL_BITS-1:0] eff_col;
  logic                need_pre;
  logic                s1_free;
  logic                accept;
  logic                pre_go;
  logic                is_centre;

  assign cfg_ready = 1'b1;

  // width in use, saturated to 1..MAX_WIDTH, as last column index
  always_comb begin
    wdec = width_r - CFG_BITS'(1);
    if (width_r == '0) begin
      wm1 = '0;
    end else if (width_r > CFG_BITS'(MAX_WIDTH)) begin
      wm1 = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      wm1 = wdec[COL_BITS-1:0];
    end
  end

  assign col      = (count_r > wm1) ? wm1 : count_r;
  assign col_m1   = col - COL_BITS'(1);
  assign col_p1   = col + COL_BITS'(1);
  assign last     = (col == wm1);
  assign is_drain = (in_op == OP_DRAIN);

  // the word in the read stage is the newest left-neighbor candidate
  assign eff_ok  = stage.busy ? 1'b1 : d_ok_r;
  assign eff_col = stage.busy ? stage.col : d_col_r;

  // left neighbor not at hand (row restart after a width change): fetch it first
  assign need_pre = in_valid && !filling_r && (col != '0) &&
                    !(eff_ok && (eff_col == col_m1));
  assign s1_free  = !stage.busy || stage.adv;
  assign in_ready = (st_r == ST_RUN) && !need_pre && s1_free;
  assign accept   = in_valid && in_ready;
  assign pre_go   = (st_r == ST_RUN) && need_pre && s1_free;

  always_comb begin
    issue.valid   = accept && !filling_r;
    issue.col     = col;
    issue.last    = last;
    issue.drain   = is_drain;
    issue.pixel   = in_pixel;
    issue.top_row = top_r;
    issue.sel     = sel_r;
    issue.d_hold  = d_hold_r;
  end

  // sel_r == 0: ram 0 holds the centre row, ram 1 the upper row
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      is_centre = (sel_r == 1'(i));
      ram_ctl[i].waddr  = col;
      ram_ctl[i].wdata  = in_pixel;
      ram_ctl[i].we     = accept && !is_drain && (filling_r == is_centre);
      ram_ctl[i].re     = (accept && !filling_r) || (pre_go && is_centre);
      ram_ctl[i].raddr0 = (pre_go && is_centre) ? col_m1 : col;
      ram_ctl[i].raddr1 = col_p1;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    width_nxt   = width_r;
    count_nxt   = count_r;
    sel_nxt     = sel_r;
    filling_nxt = filling_r;
    top_nxt     = top_r;
    d_hold_nxt  = d_hold_r;
    d_col_nxt   = d_col_r;
    d_ok_nxt    = d_ok_r;
    pre_col_nxt = pre_col_r;

    if (cfg_valid && cfg_ready) begin
      width_nxt = cfg_data;
    end

    unique case (st_r)
      ST_RUN: begin
        if (pre_go) begin
          st_nxt      = ST_CAP;
          pre_col_nxt = col_m1;
        end
      end
      ST_CAP: begin
        st_nxt = ST_RUN;
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase

    priority if (accept && filling_r && !is_drain) begin
      d_ok_nxt = 1'b0;
    end else if (st_r == ST_CAP) begin
      d_hold_nxt = sel_r ? ram1_rd0 : ram0_rd0;
      d_col_nxt  = pre_col_r;
      d_ok_nxt   = 1'b1;
    end else if (stage.adv) begin
      d_hold_nxt = stage.e;
      d_col_nxt  = stage.col;
      d_ok_nxt   = 1'b1;
    end else begin
      d_ok_nxt = d_ok_r;
    end

    if (accept) begin
      priority if (is_drain && filling_r) begin
        count_nxt = count_r;
      end else if (is_drain) begin
        if (last) begin
          count_nxt   = '0;
          filling_nxt = 1'b1;
          top_nxt     = 1'b1;
        end else begin
          count_nxt = col_p1;
        end
      end else if (filling_r) begin
        if (last) begin
          count_nxt   = '0;
          filling_nxt = 1'b0;
        end else begin
          count_nxt = col_p1;
        end
      end else begin
        if (last) begin
          count_nxt = '0;
          sel_nxt   = ~sel_r;
          top_nxt   = 1'b0;
        end else begin
          count_nxt = col_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_RUN;
      width_r   <= WIDTH_RESET;
      count_r   <= '0;
      sel_r     <= 1'b0;
      filling_r <= 1'b1;
      top_r     <= 1'b1;
      d_ok_r    <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      width_r   <= width_nxt;
      count_r   <= count_nxt;
      sel_r     <= sel_nxt;
      filling_r <= filling_nxt;
      top_r     <= top_nxt;
      d_ok_r    <= d_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_hold_r  <= d_hold_nxt;
    d_col_r   <= d_col_nxt;
    pre_col_r <= pre_col_nxt;
  end

endmodule

// ===== hw/rtl/s2x_kernel.sv =====
// Read stage and Scale2x rule, followed by the output register.
`timescale 1ns / 1ps
module s2x_kernel import s2x_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  s2x_issue_t            issue,
  output s2x_stage_t            stage,
  input  logic [PIXEL_BITS-1:0] ram0_rd0,
  input  logic [PIXEL_BITS-1:0] ram0_rd1,
  input  logic [PIXEL_BITS-1:0] ram1_rd0,
  input  logic [PIXEL_BITS-1:0] ram1_rd1,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_top_left,
  output logic [PIXEL_BITS-1:0] out_top_right,
  output logic [PIXEL_BITS-1:0] out_bottom_left,
  output logic [PIXEL_BITS-1:0] out_bottom_right,
  output logic [COL_BITS-1:0]   out_centre_column,
  output logic                  out_row_end,
  output logic                  out_frame_end
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [COL_BITS-1:0]   s1_col_r;
  logic                  s1_last_r;
  logic                  s1_drain_r;
  logic [PIXEL_BITS-1:0] s1_pixel_r;
  logic                  s1_top_r;
  logic                  s1_sel_r;
  logic [PIXEL_BITS-1:0] s1_d_r;
  logic                  out_valid_r, out_valid_nxt;

  logic [PIXEL_BITS-1:0] e, b, d, f, h;
  logic [PIXEL_BITS-1:0] tl, tr, bl, br;
  logic                  adv;

  assign adv = s1_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    stage.busy = s1_valid_r;
    stage.adv  = adv;
    stage.col  = s1_col_r;
    stage.e    = e;
  end

  // centre row sits in ram 0 unless the stores have swapped
  always_comb begin
    e = s1_sel_r ? ram1_rd0 : ram0_rd0;
    b = s1_top_r ? e : (s1_sel_r ? ram0_rd0 : ram1_rd0);
    d = (s1_col_r == '0) ? e : s1_d_r;
    f = s1_last_r ? e : (s1_sel_r ? ram1_rd1 : ram0_rd1);
    h = s1_drain_r ? e : s1_pixel_r;
    if ((b != h) && (d != f)) begin
      tl = (d == b) ? d : e;
      tr = (b == f) ? f : e;
      bl = (d == h) ? d : e;
      br = (h == f) ? f : e;
    end else begin
      tl = e;
      tr = e;
      bl = e;
      br = e;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue.valid) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_col_r   <= issue.col;
      s1_last_r  <= issue.last;
      s1_drain_r <= issue.drain;
      s1_pixel_r <= issue.pixel;
      s1_top_r   <= issue.top_row;
      s1_sel_r   <= issue.sel;
      // left neighbor: centre of the word now leaving, else the held one
      s1_d_r     <= s1_valid_r ? e : issue.d_hold;
    end
    if (adv) begin
      out_top_left      <= tl;
      out_top_right     <= tr;
      out_bottom_left   <= bl;
      out_bottom_right  <= br;
      out_centre_column <= s1_col_r;
      out_row_end       <= s1_last_r;
      out_frame_end     <= s1_last_r && s1_drain_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== test/s2x_scoreboard_pkg.sv =====
// Scoreboard class for the Scale2x upscaler testbench: line store predictor and result checker.
`timescale 1ns / 1ps
package s2x_scoreboard_pkg;
  import s2x_pkg::*;

  class scale2x_scoreboard;
    typedef struct {
      logic [PIXEL_BITS-1:0] top_left;
      logic [PIXEL_BITS-1:0] top_right;
      logic [PIXEL_BITS-1:0] bottom_left;
      logic [PIXEL_BITS-1:0] bottom_right;
      logic [COL_BITS-1:0]   column;
      logic                  row_end;
      logic                  frame_end;
    } block_t;

    // line_a holds the centre row while swapped is low, line_b the row above
    logic [PIXEL_BITS-1:0] line_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line_b [MAX_WIDTH];
    int unsigned           col_pos;
    bit                    swapped;
    bit                    filling;
    bit                    top_row;
    logic [CFG_BITS-1:0]   width_reg;
    block_t                expected_blocks[$];
    int                    errors;
    int unsigned           live_words;

    function new();
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      col_pos    = 0;
      swapped    = 1'b0;
      filling    = 1'b1;
      top_row    = 1'b1;
      width_reg  = WIDTH_RESET;
      errors     = 0;
      live_words = 0;
    endfunction

    function void set_width(logic [CFG_BITS-1:0] v);
      width_reg = v;
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction

    function logic [PIXEL_BITS-1:0] centre_px(int unsigned i);
      return swapped ? line_b[i] : line_a[i];
    endfunction

    function logic [PIXEL_BITS-1:0] upper_px(int unsigned i);
      return swapped ? line_a[i] : line_b[i];
    endfunction

    // 2x2 block for centre column c; neighbors past an edge fall back to the centre
    function block_t predict_block(int unsigned c, int unsigned w,
                                   logic [PIXEL_BITS-1:0] below, bit drain);
      block_t                blk;
      logic [PIXEL_BITS-1:0] e, b, d, f, h;
      bit                    last;
      last = (c + 1 >= w);
      e = centre_px(c);
      b = top_row ? e : upper_px(c);
      d = (c == 0) ? e : centre_px(c - 1);
      f = last ? e : centre_px(c + 1);
      h = drain ? e : below;
      if (b != h && d != f) begin
        blk.top_left     = (d == b) ? d : e;
        blk.top_right    = (b == f) ? f : e;
        blk.bottom_left  = (d == h) ? d : e;
        blk.bottom_right = (h == f) ? f : e;
      end else begin
        blk.top_left     = e;
        blk.top_right    = e;
        blk.bottom_left  = e;
        blk.bottom_right = e;
      end
      blk.column    = COL_BITS'(c);
      blk.row_end   = last;
      blk.frame_end = last && drain;
      return blk;
    endfunction

    // Notes one accepted input word; returns 1 when it closed a row (or the frame, for drains).
    function bit note_word(logic op, logic [PIXEL_BITS-1:0] px);
      int unsigned w, c;
      bit          last;
      w = active_width();
      c = col_pos;
      if (c >= w) c = w - 1;
      last = (c + 1 >= w);
      if (op == OP_DRAIN) begin
        if (filling) return 1'b0;
        live_words++;
        expected_blocks.push_back(predict_block(c, w, '0, 1'b1));
        if (last) begin
          col_pos = 0;
          filling = 1'b1;
          top_row = 1'b1;
        end else begin
          col_pos = c + 1;
        end
        return last;
      end
      live_words++;
      if (filling) begin
        if (swapped) line_b[c] = px;
        else line_a[c] = px;
        if (last) begin
          col_pos = 0;
          filling = 1'b0;
        end else begin
          col_pos = c + 1;
        end
        return last;
      end
      expected_blocks.push_back(predict_block(c, w, px, 1'b0));
      if (swapped) line_a[c] = px;
      else line_b[c] = px;
      if (last) begin
        col_pos = 0;
        swapped = !swapped;
        top_row = 1'b0;
      end else begin
        col_pos = c + 1;
      end
      return last;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_block(logic [PIXEL_BITS-1:0] tl, logic [PIXEL_BITS-1:0] tr,
                              logic [PIXEL_BITS-1:0] bl, logic [PIXEL_BITS-1:0] br,
                              logic [COL_BITS-1:0] col, logic re, logic fe);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("result word at column %0d with no prediction waiting", col);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      compare("out_top_left", want.top_left, tl);
      compare("out_top_right", want.top_right, tr);
      compare("out_bottom_left", want.bottom_left, bl);
      compare("out_bottom_right", want.bottom_right, br);
      compare("out_centre_column", 32'(want.column), 32'(col));
      compare("out_row_end", 32'(want.row_end), 32'(re));
      compare("out_frame_end", 32'(want.frame_end), 32'(fe));
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench of the Scale2x upscaler core: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import s2x_pkg::*;
  import s2x_scoreboard_pkg::*;

  localparam int RUN_LIMIT     = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PREFILL_WIDTH = 128;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_op     = OP_PIXEL;
  logic [PIXEL_BITS-1:0] in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [PIXEL_BITS-1:0] out_top_left;
  logic [PIXEL_BITS-1:0] out_top_right;
  logic [PIXEL_BITS-1:0] out_bottom_left;
  logic [PIXEL_BITS-1:0] out_bottom_right;
  logic [COL_BITS-1:0]   out_centre_column;
  logic                  out_row_end;
  logic                  out_frame_end;

  scale2x_scoreboard     sb = new();
  int                    in_idle_pct  = 33;
  int                    out_idle_pct = 46;
  int                    rx_hold_req  = 0;
  int                    cycle_count  = 0;
  logic [PIXEL_BITS-1:0] palette [4];
  int                    palette_size = 2;

  scale2x_pixel_upscaler_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_top_left      (out_top_left),
    .out_top_right     (out_top_right),
    .out_bottom_left   (out_bottom_left),
    .out_bottom_right  (out_bottom_right),
    .out_centre_column (out_centre_column),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: checks accepted words, stalls at random or for a requested stretch
  initial begin : receive_loop
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready)
        sb.check_block(out_top_left, out_top_right, out_bottom_left, out_bottom_right,
                       out_centre_column, out_row_end, out_frame_end);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [PIXEL_BITS-1:0] px, output bit done);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= px;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    done = sb.note_word(op, px);
  endtask

  // drain everything in flight; the extra cycles cover words that produce no result
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_BITS-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_width(v);
  endtask

  task automatic new_palette();
    palette_size = $urandom_range(2, 4);
    for (int i = 0; i < 4; i++) palette[i] = $urandom();
  endtask

  // a small palette makes neighbor matches common enough to hit every rule branch
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    if ($urandom_range(99) < 85) return palette[$urandom_range(palette_size - 1)];
    return $urandom();
  endfunction

  function automatic logic [CFG_BITS-1:0] frame_width();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return CFG_BITS'($urandom_range(25, 64));
    return CFG_BITS'($urandom_range(1, 12));
  endfunction

  task automatic run_frame();
    int unsigned          rows, r, n, cut, at, shrink_after;
    bit                   done, broken, regrow, noise, dummy;
    logic [CFG_BITS-1:0]  v;
    if ($urandom_range(2) == 0) write_width(frame_width());
    new_palette();
    rows         = $urandom_range(1, 5);
    shrink_after = 0;
    for (r = 0; r < rows; r++) begin
      broken = (r > 0) && (r == rows - 1) && ($urandom_range(5) == 0);
      cut    = (sb.active_width() > 1) ? $urandom_range(1, sb.active_width() - 1) : 1;
      regrow = ($urandom_range(11) == 0);
      noise  = (r == 0) && ($urandom_range(7) == 0);
      at     = $urandom_range(0, sb.active_width() - 1);
      n      = 0;
      done   = 1'b0;
      while (!done && !(broken && n == cut)) begin
        if (regrow && n == at) begin
          // all-ones width saturates to the maximum; pull it back a few words later
          if ($urandom_range(3) == 0) begin
            v            = '1;
            shrink_after = $urandom_range(1, 3);
            broken       = 1'b0;
          end else begin
            v = CFG_BITS'($urandom_range(1, 24));
          end
          write_width(v);
        end
        if (noise && n == at) send_word(OP_DRAIN, $urandom(), dummy);
        send_word(OP_PIXEL, pick_pixel(), done);
        n++;
        if (shrink_after != 0) begin
          shrink_after--;
          if (shrink_after == 0) write_width(CFG_BITS'($urandom_range(1, 24)));
        end
      end
    end
    done = 1'b0;
    while (!done) send_word(OP_DRAIN, $urandom(), done);
    // a drain word at frame start is dropped by the block
    if ($urandom_range(7) == 0) send_word(OP_DRAIN, $urandom(), dummy);
  endtask

  initial begin : stimulus
    bit          done;
    int unsigned base_words;
    logic [PIXEL_BITS-1:0] p0, p1, p2;
    p0 = 32'h0000_0000;
    p1 = 32'hFFFF_FFFF;
    p2 = 32'h5A5A_A5A5;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drain before any row, 3-wide frame ended by a drain in mid-row
    send_word(OP_DRAIN, p1, done);
    write_width(CFG_BITS'(3));
    send_word(OP_PIXEL, p0, done);
    send_word(OP_DRAIN, p2, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_PIXEL, p0, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_PIXEL, p0, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_PIXEL, p0, done);
    send_word(OP_PIXEL, p0, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_PIXEL, p2, done);
    send_word(OP_DRAIN, p0, done);
    send_word(OP_DRAIN, p1, done);
    // single-column and two-column frames
    write_width(CFG_BITS'(1));
    send_word(OP_PIXEL, p1, done);
    send_word(OP_PIXEL, p2, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_DRAIN, p0, done);
    write_width(CFG_BITS'(2));
    send_word(OP_PIXEL, p2, done);
    send_word(OP_PIXEL, p2, done);
    send_word(OP_PIXEL, p0, done);
    send_word(OP_PIXEL, p1, done);
    send_word(OP_DRAIN, p0, done);
    send_word(OP_DRAIN, p0, done);

    // two-row frame; it writes every entry that a later width regrow can reach
    new_palette();
    write_width(CFG_BITS'(PREFILL_WIDTH));
    for (int k = 0; k < 2 * PREFILL_WIDTH; k++) send_word(OP_PIXEL, pick_pixel(), done);
    write_width('0);
    send_word(OP_DRAIN, $urandom(), done);

    base_words = sb.live_words;
    while (sb.live_words < base_words + 540) run_frame();
    in_idle_pct  = 46;
    out_idle_pct = 33;
    while (sb.live_words < base_words + 1080) run_frame();

    // backpressure: receiver holds off while the sender keeps offering words
    write_width(CFG_BITS'(16));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    rx_hold_req  = HOLD_CYCLES;
    new_palette();
    for (int k = 0; k < 48; k++) send_word(OP_PIXEL, pick_pixel(), done);
    done = 1'b0;
    while (!done) send_word(OP_DRAIN, $urandom(), done);

    while (sb.live_words < base_words + 1620) run_frame();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
